// File: hdl/first_fit_heap_allocator_unit_macros.svh
// Assertion macros used by the allocator RTL
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define FFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define FFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define FFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/ffa_pkg.sv
package ffa_pkg;

    localparam int FW = 21;
    localparam int VW = 34;

    localparam logic [VW-1:0] DEF_HEAP_BYTES = VW'(1048576);
    localparam int DEF_BLOCK_BYTES  = 64;
    localparam int DEF_HEADER_BYTES = 24;
    localparam int DEF_SEGMENTS     = 64;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic          req_type;
        logic [FW-1:0] req_size;
        logic [FW-1:0] req_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic [FW-1:0] alloc_addr;
        logic [FW-1:0] free_bytes;
        logic [FW-1:0] largest_free;
    } t_rsp;

    typedef struct packed {
        logic [VW-1:0] start;
        logic [VW-1:0] size;
    } t_seg;

    typedef struct packed {
        logic mod_en;
        logic del_en;
        logic ins_en;
        t_seg mod_val;
        t_seg ins_val;
    } t_edit;

endpackage

// File: hdl/ffa_cell.sv
module ffa_cell (
    input  logic         i_clk,
    input  logic         i_en,
    input  ffa_pkg::t_seg i_seg,
    output ffa_pkg::t_seg o_seg
);
    import ffa_pkg::*;

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= i_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

// File: hdl/ffa_ring.sv
module ffa_ring #(
    parameter int                     N        = ffa_pkg::DEF_SEGMENTS,
    parameter logic [ffa_pkg::VW-1:0] RST_SIZE = '0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_run,
    input  logic                     i_wrap,
    input  logic [$clog2(N+1)-1:0]   i_j,
    input  ffa_pkg::t_edit           i_ed,
    input  logic [$clog2(N+1)-1:0]   i_mod_idx,
    input  logic [$clog2(N+1)-1:0]   i_del_idx,
    input  logic [$clog2(N+1)-1:0]   i_ins_idx,
    output ffa_pkg::t_seg            o_emit
);
    import ffa_pkg::*;

    typedef enum logic [1:0] {M_NORM, M_BYP, M_DBL} t_mode;

    t_mode r_mode, n_mode;
    t_seg  r_d, n_d;
    t_seg  r_e, n_e;
    t_seg  w_emit;
    t_seg  w_link [N+1];

    assign w_link[N] = w_emit;

    for (genvar k = 0; k < N; k++) begin : g_cell
        ffa_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_run),
            .i_seg (w_link[k+1]),
            .o_seg (w_link[k])
        );
    end

    always_comb begin
        n_d    = r_d;
        n_e    = r_e;
        n_mode = r_mode;
        w_emit = r_d;
        if (i_wrap) begin
            w_emit = (r_mode == M_BYP) ? w_link[0] : r_d;
            n_d    = w_link[0];
            n_mode = M_NORM;
        end else begin
            case (r_mode)
                M_NORM: begin
                    if (i_ed.del_en && (i_j == i_del_idx)) begin
                        w_emit = w_link[0];
                        n_mode = M_BYP;
                    end else if (i_ed.ins_en && (i_j == i_ins_idx)) begin
                        w_emit = i_ed.ins_val;
                        n_e    = w_link[0];
                        n_mode = M_DBL;
                    end else begin
                        w_emit = (i_ed.mod_en && (i_j == i_mod_idx)) ? i_ed.mod_val : r_d;
                        n_d    = w_link[0];
                    end
                end
                M_BYP: begin
                    w_emit = w_link[0];
                end
                M_DBL: begin
                    w_emit = r_d;
                    n_d    = r_e;
                    n_e    = w_link[0];
                end
                default: begin
                    n_mode = M_NORM;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORM;
            r_d    <= '{start: '0, size: RST_SIZE};
        end else if (i_run) begin
            r_mode <= n_mode;
            r_d    <= n_d;
            r_e    <= n_e;
        end
    end

    assign o_emit = w_emit;

endmodule

// File: hdl/first_fit_heap_allocator_unit.sv
// channel   | valid       | ready        | beat
// request   | i_in_valid  | o_in_ready   | i_in_data  (t_req)
// result    | o_out_valid | i_out_ready  | o_out_data (t_rsp)
//
// One request at a time; o_in_ready is high only while idle.
// Each pass rotates both segment rings once.
// Allocate: S_ROUND, S_NEED, one scan pass, S_FIX1, S_FIX2, one edit pass, S_HOLD.
// Free: two scan passes, S_FIX1, S_FIX2, one edit pass, S_HOLD.
// Reset (synchronous, active low) leaves one free segment covering the heap.
// A result held in the output register stalls only the finish of the next request.
module first_fit_heap_allocator_unit #(
    parameter logic [ffa_pkg::VW-1:0] HEAP_BYTES   = ffa_pkg::DEF_HEAP_BYTES,
    parameter int                     BLOCK_BYTES  = ffa_pkg::DEF_BLOCK_BYTES,
    parameter int                     HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
    parameter int                     MAX_SEGMENTS = ffa_pkg::DEF_SEGMENTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ffa_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ffa_pkg::t_rsp o_out_data
);
    import ffa_pkg::*;

    `include "first_fit_heap_allocator_unit_macros.svh"

    localparam int N  = MAX_SEGMENTS;
    localparam int JW = $clog2(N+1);
    localparam int XW = FW + 1;
    localparam int LB = $clog2(BLOCK_BYTES);
    localparam int SH = XW + LB;
    localparam int PW = 2 * XW + 1;
    localparam logic [XW:0] RECIP = (XW+1)'(((longint'(1) << SH) + longint'(BLOCK_BYTES) - 1)
                                            / longint'(BLOCK_BYTES));
    localparam logic [JW-1:0] LAST = JW'(N);
    localparam logic [VW-1:0] HDR  = VW'(HEADER_BYTES);
    localparam logic [VW-1:0] BLK  = VW'(BLOCK_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_ROUND, S_NEED, S_SCANU, S_SCANF, S_FIX1, S_FIX2, S_EDIT, S_HOLD
    } t_state;

    t_state        r_state;
    t_req          r_req;
    logic [JW-1:0] r_j, r_fc, r_uc, r_idx, r_u;
    logic [JW-1:0] r_fmod, r_fdel, r_fins, r_udel, r_uins;
    logic [XW-1:0] r_q, w_x;
    logic [PW-1:0] w_prod;
    logic [VW-1:0] r_need, r_rem, r_tmp, r_head, r_sz, r_end, r_sz2;
    logic [VW-1:0] r_psum, r_psz, r_nsz, r_addr, r_tot, r_big;
    logic          r_found, r_prev_v, r_split, r_nadj, r_padj, w_nadj;
    t_seg          r_seg, r_prev;
    t_edit         r_fed, r_ued;
    logic [1:0]    r_status;
    logic          r_ovalid;
    t_rsp          r_out;
    logic          w_run, w_wrap;
    t_seg          w_ef, w_eu;

    assign w_run  = (r_state == S_SCANU) || (r_state == S_SCANF) || (r_state == S_EDIT);
    assign w_wrap = (r_j == LAST);
    assign w_x    = XW'(r_req.req_size) + XW'(BLOCK_BYTES - 1);
    assign w_prod = PW'(w_x) * PW'(RECIP);
    assign w_nadj = r_found && (r_end == r_seg.start);

    ffa_ring #(.N(N), .RST_SIZE(HEAP_BYTES - HDR)) u_free_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run     (w_run),
        .i_wrap    (w_wrap),
        .i_j       (r_j),
        .i_ed      (r_fed),
        .i_mod_idx (r_fmod),
        .i_del_idx (r_fdel),
        .i_ins_idx (r_fins),
        .o_emit    (w_ef)
    );

    ffa_ring #(.N(N), .RST_SIZE('0)) u_used_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run     (w_run),
        .i_wrap    (w_wrap),
        .i_j       (r_j),
        .i_ed      (r_ued),
        .i_mod_idx (r_udel),
        .i_del_idx (r_udel),
        .i_ins_idx (r_uins),
        .o_emit    (w_eu)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fc     <= JW'(1);
            r_uc     <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_in_data;
                        r_j      <= '0;
                        r_found  <= 1'b0;
                        r_prev_v <= 1'b0;
                        r_fed    <= '0;
                        r_ued    <= '0;
                        r_status <= ST_OK;
                        r_addr   <= '0;
                        r_tot    <= '0;
                        r_big    <= '0;
                        if (i_in_data.req_type == REQ_FREE) begin
                            r_state <= S_SCANU;
                        end else if (r_uc == LAST) begin
                            r_status <= ST_FULL;
                            r_state  <= S_EDIT;
                        end else begin
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_q     <= w_prod[SH +: XW];
                    r_state <= S_NEED;
                end
                S_NEED: begin
                    r_need  <= VW'(r_q) * BLK;
                    r_state <= S_SCANF;
                end
                S_SCANU: begin
                    r_j <= r_j + 1'b1;
                    if (!r_found && (r_j < r_uc) && (w_eu.start + HDR == VW'(r_req.req_addr))) begin
                        r_found <= 1'b1;
                        r_u     <= r_j;
                        r_head  <= w_eu.start;
                        r_sz    <= w_eu.size;
                        r_end   <= VW'(r_req.req_addr) + w_eu.size;
                    end
                    if (w_wrap) begin
                        r_j     <= '0;
                        r_found <= 1'b0;
                        if (r_found) begin
                            r_state <= S_SCANF;
                        end else begin
                            r_status <= ST_BADADDR;
                            r_state  <= S_EDIT;
                        end
                    end
                end
                S_SCANF: begin
                    r_j <= r_j + 1'b1;
                    if (!r_found && (r_j < r_fc)) begin
                        if (r_req.req_type == REQ_ALLOC) begin
                            if (w_ef.size >= r_need) begin
                                r_found <= 1'b1;
                                r_idx   <= r_j;
                                r_seg   <= w_ef;
                                r_rem   <= w_ef.size - r_need;
                            end
                        end else if (w_ef.start >= r_head) begin
                            r_found <= 1'b1;
                            r_idx   <= r_j;
                            r_seg   <= w_ef;
                            r_nsz   <= w_ef.size + HDR;
                        end else begin
                            r_prev   <= w_ef;
                            r_prev_v <= 1'b1;
                            r_psum   <= w_ef.start + w_ef.size;
                            r_psz    <= w_ef.size + HDR;
                        end
                    end
                    if (w_wrap) begin
                        r_j <= '0;
                        if ((r_req.req_type == REQ_ALLOC) && !r_found) begin
                            r_status <= ST_NOSPACE;
                            r_state  <= S_EDIT;
                        end else begin
                            r_state <= S_FIX1;
                        end
                    end
                end
                S_FIX1: begin
                    r_split <= (r_rem >= HDR);
                    r_tmp   <= r_seg.start + HDR;
                    r_nadj  <= w_nadj;
                    r_padj  <= r_prev_v && (r_psum + HDR == r_head);
                    r_sz2   <= r_sz + (w_nadj ? r_nsz : '0);
                    if (!r_found) begin
                        r_idx <= r_fc;
                    end
                    r_state <= S_FIX2;
                end
                S_FIX2: begin
                    r_state <= S_EDIT;
                    if (r_req.req_type == REQ_ALLOC) begin
                        r_addr         <= r_tmp;
                        r_ued.ins_en   <= 1'b1;
                        r_ued.ins_val  <= '{start: r_seg.start,
                                           size: r_split ? r_need : r_seg.size};
                        r_uins         <= r_uc;
                        r_uc           <= r_uc + 1'b1;
                        if (r_split) begin
                            r_fed.mod_en  <= 1'b1;
                            r_fed.mod_val <= '{start: r_tmp + r_need, size: r_rem - HDR};
                            r_fmod        <= r_idx;
                        end else begin
                            r_fed.del_en <= 1'b1;
                            r_fdel       <= r_idx;
                            r_fc         <= r_fc - 1'b1;
                        end
                    end else if (!r_nadj && !r_padj && (r_fc == LAST)) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_ued.del_en <= 1'b1;
                        r_udel       <= r_u;
                        r_uc         <= r_uc - 1'b1;
                        if (r_padj) begin
                            r_fed.mod_en  <= 1'b1;
                            r_fed.mod_val <= '{start: r_prev.start, size: r_psz + r_sz2};
                            r_fmod        <= r_idx - 1'b1;
                            if (r_nadj) begin
                                r_fed.del_en <= 1'b1;
                                r_fdel       <= r_idx;
                                r_fc         <= r_fc - 1'b1;
                            end
                        end else if (r_nadj) begin
                            r_fed.mod_en  <= 1'b1;
                            r_fed.mod_val <= '{start: r_head, size: r_sz2};
                            r_fmod        <= r_idx;
                        end else begin
                            r_fed.ins_en  <= 1'b1;
                            r_fed.ins_val <= '{start: r_head, size: r_sz};
                            r_fins        <= r_idx;
                            r_fc          <= r_fc + 1'b1;
                        end
                    end
                end
                S_EDIT: begin
                    r_j <= r_j + 1'b1;
                    if (r_j < r_fc) begin
                        r_tot <= r_tot + w_ef.size;
                        if (w_ef.size > r_big) begin
                            r_big <= w_ef.size;
                        end
                    end
                    if (w_wrap) begin
                        r_j     <= '0;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '{status: r_status,
                                      alloc_addr: r_addr[FW-1:0],
                                      free_bytes: r_tot[FW-1:0],
                                      largest_free: r_big[FW-1:0]};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `FFA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_fc <= LAST) && (r_uc <= LAST))
    `FFA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)
    `FFA_ASSERT_NXT(a_pass_done, i_clk, i_rst_n, (r_state == S_EDIT) && w_wrap, r_state == S_HOLD)

endmodule
